FILE: hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/tfcg_pkg.sv
package tfcg_pkg;

  // threshold registers are fixed width
  localparam int THR_BITS = 18;
  typedef logic [THR_BITS-1:0] thr_t;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_FLOOR    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CEILING  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL = 3'd4;

  // reset values
  localparam int unsigned FLOOR_RST   = 800000;
  localparam int unsigned CEILING_RST = 3000000;
  localparam thr_t        NORMAL_RST   = 18'd50000;
  localparam thr_t        TOLERATE_RST = 18'd70000;
  localparam thr_t        CRITICAL_RST = 18'd90000;

  typedef enum logic [2:0] {
    ZONE_PS   = 3'd0,
    ZONE_HOT  = 3'd1,
    ZONE_WARM = 3'd2,
    ZONE_COOL = 3'd3,
    ZONE_NEG  = 3'd4
  } zone_e;

  // control that travels with each item down the pipe
  typedef struct packed {
    logic  valid;
    zone_e zone;
    logic  zden;   // zero step denominator, step is the full range
    logic  qneg;   // quotient sign
  } tag_t;

endpackage

FILE: hw/rtl/tfcg_front.sv
module tfcg_front #(
  parameter int FREQ_BITS = 24,
  parameter int TEMP_BITS = 19,
  parameter int DIFF_W    = 20,
  parameter int NUM_W     = 43,
  parameter int DEN_W     = 22
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        adv_i,
  input  logic                        in_valid_i,
  input  logic signed [TEMP_BITS-1:0] temp_i,
  input  logic [FREQ_BITS-1:0]        cur_i,
  input  logic                        ps_i,
  input  logic [FREQ_BITS-1:0]        floor_i,
  input  logic [FREQ_BITS-1:0]        ceil_i,
  input  tfcg_pkg::thr_t              normal_i,
  input  tfcg_pkg::thr_t              tol_i,
  input  tfcg_pkg::thr_t              crit_i,
  output tfcg_pkg::tag_t              tag_o,
  output logic [FREQ_BITS-1:0]        cur_o,
  output logic [NUM_W-1:0]            num_o,
  output logic [DEN_W-1:0]            den_o
);

  localparam int SPAN_W = tfcg_pkg::THR_BITS + 1;
  localparam int RNG_W  = FREQ_BITS + 1;
  localparam int MAG_W  = DIFF_W - 1;

  // stage 1: zone decode and distance above the threshold
  logic signed [DIFF_W-1:0] t_ext, dtol, dnrm, diff_d;
  logic signed [SPAN_W-1:0] span_hot, span_warm, span_d;
  tfcg_pkg::zone_e          zone_d;

  assign t_ext     = DIFF_W'(temp_i);
  assign dtol      = t_ext - $signed(DIFF_W'(tol_i));
  assign dnrm      = t_ext - $signed(DIFF_W'(normal_i));
  assign span_hot  = $signed(SPAN_W'(crit_i)) - $signed(SPAN_W'(tol_i));
  assign span_warm = $signed(SPAN_W'(tol_i)) - $signed(SPAN_W'(normal_i));

  always_comb begin
    diff_d = '0;
    span_d = '0;
    if (ps_i) begin
      zone_d = tfcg_pkg::ZONE_PS;
    end else if (!dtol[DIFF_W-1]) begin
      zone_d = tfcg_pkg::ZONE_HOT;
      diff_d = dtol;
      span_d = span_hot;
    end else if (!dnrm[DIFF_W-1]) begin
      zone_d = tfcg_pkg::ZONE_WARM;
      diff_d = dnrm;
      span_d = span_warm;
    end else if (!temp_i[TEMP_BITS-1]) begin
      zone_d = tfcg_pkg::ZONE_COOL;
    end else begin
      zone_d = tfcg_pkg::ZONE_NEG;
    end
  end

  tfcg_pkg::tag_t           tag1_q, tag2_q, tag3_q;
  logic [FREQ_BITS-1:0]     cur1_q, cur2_q, cur3_q;
  logic signed [DIFF_W-1:0] diff1_q;
  logic signed [SPAN_W-1:0] span1_q;

  // stage 2: magnitudes and sign of the quotient
  logic signed [RNG_W-1:0]       range;
  logic                          dneg, sneg, rneg;
  logic [MAG_W-1:0]              dmag_d, dmag2_q;
  logic [tfcg_pkg::THR_BITS-1:0] smag_d, smag2_q;
  logic [FREQ_BITS-1:0]          rmag_d, rmag2_q;
  logic signed [DIFF_W-1:0]      diff_neg;
  logic signed [SPAN_W-1:0]      span_neg;
  logic signed [RNG_W-1:0]       range_neg;

  assign range     = $signed({1'b0, ceil_i}) - $signed({1'b0, floor_i});
  assign dneg      = diff1_q[DIFF_W-1];
  assign sneg      = span1_q[SPAN_W-1];
  assign rneg      = range[RNG_W-1];
  assign diff_neg  = -diff1_q;
  assign span_neg  = -span1_q;
  assign range_neg = -range;
  assign dmag_d    = dneg ? diff_neg[MAG_W-1:0] : diff1_q[MAG_W-1:0];
  assign smag_d    = sneg ? span_neg[tfcg_pkg::THR_BITS-1:0]
                          : span1_q[tfcg_pkg::THR_BITS-1:0];
  assign rmag_d    = rneg ? range_neg[FREQ_BITS-1:0] : range[FREQ_BITS-1:0];

  // stage 3: product and ten times the span
  logic [NUM_W-1:0] num_d, num3_q;
  logic [DEN_W-1:0] den_d, den3_q;

  assign num_d = NUM_W'(rmag2_q) * NUM_W'(dmag2_q);
  assign den_d = DEN_W'({smag2_q, 3'b000}) + DEN_W'({smag2_q, 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
      tag3_q <= '0;
    end else if (adv_i) begin
      tag1_q.valid <= in_valid_i;
      tag1_q.zone  <= zone_d;
      tag1_q.zden  <= 1'b0;
      tag1_q.qneg  <= 1'b0;
      tag2_q.valid <= tag1_q.valid;
      tag2_q.zone  <= tag1_q.zone;
      tag2_q.zden  <= (span1_q == '0);
      tag2_q.qneg  <= dneg ^ sneg ^ rneg;
      tag3_q       <= tag2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cur1_q  <= cur_i;
      diff1_q <= diff_d;
      span1_q <= span_d;
      cur2_q  <= cur1_q;
      dmag2_q <= dmag_d;
      smag2_q <= smag_d;
      rmag2_q <= rmag_d;
      cur3_q  <= cur2_q;
      num3_q  <= num_d;
      den3_q  <= den_d;
    end
  end

  assign tag_o = tag3_q;
  assign cur_o = cur3_q;
  assign num_o = num3_q;
  assign den_o = den3_q;

endmodule

FILE: hw/rtl/tfcg_div_cell.sv
`include "assert_macros.svh"

module tfcg_div_cell #(
  parameter int FREQ_BITS = 24,
  parameter int NUM_W     = 43,
  parameter int DEN_W     = 22
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  tfcg_pkg::tag_t       tag_i,
  input  logic [FREQ_BITS-1:0] cur_i,
  input  logic [DEN_W-1:0]     rem_i,
  input  logic [NUM_W-1:0]     nq_i,
  input  logic [DEN_W-1:0]     den_i,
  output tfcg_pkg::tag_t       tag_o,
  output logic [FREQ_BITS-1:0] cur_o,
  output logic [DEN_W-1:0]     rem_o,
  output logic [NUM_W-1:0]     nq_o,
  output logic [DEN_W-1:0]     den_o
);

  // one restoring step: numerator bits shift out the top, quotient bits in
  logic [DEN_W:0]   r2, sub;
  logic             ge;
  logic [DEN_W-1:0] rem_d;
  logic [NUM_W-1:0] nq_d;

  assign r2    = {rem_i, nq_i[NUM_W-1]};
  assign sub   = r2 - {1'b0, den_i};
  assign ge    = (r2 >= {1'b0, den_i});
  assign rem_d = ge ? sub[DEN_W-1:0] : r2[DEN_W-1:0];
  assign nq_d  = {nq_i[NUM_W-2:0], ge};

  tfcg_pkg::tag_t       tag_q;
  logic [FREQ_BITS-1:0] cur_q;
  logic [DEN_W-1:0]     rem_q, den_q;
  logic [NUM_W-1:0]     nq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else if (adv_i) begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      cur_q <= cur_i;
      rem_q <= rem_d;
      nq_q  <= nq_d;
      den_q <= den_i;
    end
  end

  assign tag_o = tag_q;
  assign cur_o = cur_q;
  assign rem_o = rem_q;
  assign nq_o  = nq_q;
  assign den_o = den_q;

  `ASSERT_NEVER(a_rem_below_den, clk_i, rst_ni, tag_q.valid && den_q != '0 && rem_q >= den_q, "partial remainder not below divisor")

endmodule

FILE: hw/rtl/tfcg_back.sv
module tfcg_back #(
  parameter int FREQ_BITS = 24,
  parameter int NUM_W     = 43
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  out_ready_i,
  input  tfcg_pkg::tag_t        tag_i,
  input  logic [FREQ_BITS-1:0]  cur_i,
  input  logic [NUM_W-1:0]      quo_i,
  input  logic [FREQ_BITS-1:0]  floor_i,
  input  logic [FREQ_BITS-1:0]  ceil_i,
  output logic                  tail_valid_o,
  output logic                  out_valid_o,
  output logic [FREQ_BITS-1:0]  cap_o,
  output logic                  written_o,
  output tfcg_pkg::zone_e       zone_o
);

  localparam int RNG_W  = FREQ_BITS + 1;
  localparam int STEP_W = NUM_W + 1;
  localparam int V_W    = NUM_W + 2;

  // stage a: signed step
  logic signed [RNG_W-1:0]  range;
  logic signed [STEP_W-1:0] quo_s, step_d, stepa_q;

  assign range = $signed({1'b0, ceil_i}) - $signed({1'b0, floor_i});
  assign quo_s = $signed({1'b0, quo_i});

  always_comb begin
    if (tag_i.zden) begin
      step_d = STEP_W'(range);
    end else if (tag_i.qneg) begin
      step_d = -quo_s;
    end else begin
      step_d = quo_s;
    end
  end

  // stage b: move the current cap by the step
  tfcg_pkg::tag_t        taga_q, tagb_q;
  logic [FREQ_BITS-1:0]  cura_q, curb_q;
  logic signed [V_W-1:0] cur_ext, step_ext, v_d, vb_q;

  assign cur_ext  = $signed(V_W'(cura_q));
  assign step_ext = V_W'(stepa_q);
  assign v_d      = (taga_q.zone == tfcg_pkg::ZONE_HOT) ? cur_ext - step_ext
                                                        : cur_ext + step_ext;

  // output: clamp and saturate
  logic signed [V_W-1:0] lo_ext, hi_ext, max_ext;
  logic [FREQ_BITS-1:0]  cap_d;
  logic                  wr_d;

  assign lo_ext  = $signed(V_W'(floor_i));
  assign hi_ext  = $signed(V_W'(ceil_i));
  assign max_ext = $signed(V_W'({FREQ_BITS{1'b1}}));

  always_comb begin
    case (tagb_q.zone)
      tfcg_pkg::ZONE_HOT: begin
        wr_d = 1'b1;
        if (vb_q < lo_ext) begin
          cap_d = floor_i;
        end else if (vb_q > max_ext) begin
          cap_d = '1;
        end else begin
          cap_d = vb_q[FREQ_BITS-1:0];
        end
      end
      tfcg_pkg::ZONE_WARM: begin
        wr_d = 1'b1;
        if (vb_q > hi_ext) begin
          cap_d = ceil_i;
        end else if (vb_q < 0) begin
          cap_d = '0;
        end else begin
          cap_d = vb_q[FREQ_BITS-1:0];
        end
      end
      tfcg_pkg::ZONE_COOL: begin
        wr_d  = 1'b1;
        cap_d = ceil_i;
      end
      default: begin
        wr_d  = 1'b0;
        cap_d = curb_q;
      end
    endcase
  end

  logic                 out_valid_q;
  logic [FREQ_BITS-1:0] cap_q;
  logic                 written_q;
  tfcg_pkg::zone_e      zone_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      taga_q      <= '0;
      tagb_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_i) begin
        taga_q <= tag_i;
        tagb_q <= taga_q;
      end
      if (adv_i && tagb_q.valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      stepa_q <= step_d;
      cura_q  <= cur_i;
      vb_q    <= v_d;
      curb_q  <= cura_q;
    end
    if (adv_i && tagb_q.valid) begin
      cap_q     <= cap_d;
      written_q <= wr_d;
      zone_q    <= tagb_q.zone;
    end
  end

  assign tail_valid_o = tagb_q.valid;
  assign out_valid_o  = out_valid_q;
  assign cap_o        = cap_q;
  assign written_o    = written_q;
  assign zone_o       = zone_q;

endmodule

FILE: hw/rtl/thermal_frequency_cap_governor_unit.sv
// thermal frequency cap governor: each input transfer carries the hottest zone
// temperature (signed millidegrees), the cap in force (kHz) and the powersave
// flag, and yields one result transfer with the new cap, a written flag and the
// zone code (0 powersave, 1 hot, 2 warm, 3 cool, 4 negative). hot lowers the cap
// by (ceiling-floor)*(temp-tolerate)/(10*(critical-tolerate)) down to the floor,
// warm raises it by the same form over normal..tolerate up to the ceiling, cool
// sets the ceiling; division truncates toward zero and a zero span gives a full
// range step. the datapath is a pipeline: three front stages (zone decode,
// magnitudes, one 24x19 multiply), a row of FREQ_BITS+DIFF_W-1 divider cells
// that each resolve one quotient bit (43 at the defaults), two stages that sign
// and apply the step, and the output register. one transfer is taken per clock
// while the pipe advances. when the output register is full and not taken, the
// pipe keeps shifting until a result reaches its tail, then holds. configuration
// writes are always ready and must only happen while no transfer is in flight.
`include "assert_macros.svh"

module thermal_frequency_cap_governor_unit #(
  parameter int FREQ_BITS = 24,
  parameter int TEMP_BITS = 19
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [tfcg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tfcg_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // input transfers
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [TEMP_BITS-1:0]         hottest_temp_mc_i,
  input  logic [FREQ_BITS-1:0]                current_cap_khz_i,
  input  logic                                powersave_mode_i,
  // result transfers
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [FREQ_BITS-1:0]                new_cap_khz_o,
  output logic                                cap_written_o,
  output logic [2:0]                          zone_o
);

  localparam int THR_BITS = tfcg_pkg::THR_BITS;
  // temperature minus threshold, signed, wide enough for every pair
  localparam int DIFF_W = ((TEMP_BITS > THR_BITS + 1) ? TEMP_BITS : THR_BITS + 1) + 1;
  // magnitude of (ceiling-floor)*(temp-threshold)
  localparam int NUM_W  = FREQ_BITS + DIFF_W - 1;
  // magnitude of 10*(next threshold - threshold)
  localparam int DEN_W  = THR_BITS + 4;

  // configuration registers
  logic [FREQ_BITS-1:0] freq_floor_q, freq_ceiling_q;
  tfcg_pkg::thr_t       temp_normal_q, temp_tolerate_q, temp_critical_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_floor_q    <= FREQ_BITS'(tfcg_pkg::FLOOR_RST);
      freq_ceiling_q  <= FREQ_BITS'(tfcg_pkg::CEILING_RST);
      temp_normal_q   <= tfcg_pkg::NORMAL_RST;
      temp_tolerate_q <= tfcg_pkg::TOLERATE_RST;
      temp_critical_q <= tfcg_pkg::CRITICAL_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tfcg_pkg::CFG_FLOOR:    freq_floor_q    <= cfg_data_i[FREQ_BITS-1:0];
        tfcg_pkg::CFG_CEILING:  freq_ceiling_q  <= cfg_data_i[FREQ_BITS-1:0];
        tfcg_pkg::CFG_NORMAL:   temp_normal_q   <= cfg_data_i[THR_BITS-1:0];
        tfcg_pkg::CFG_TOLERATE: temp_tolerate_q <= cfg_data_i[THR_BITS-1:0];
        tfcg_pkg::CFG_CRITICAL: temp_critical_q <= cfg_data_i[THR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // whole pipe shifts unless a result waits and another sits at the tail
  logic adv, tail_valid;
  assign adv        = !out_valid_o || out_ready_i || !tail_valid;
  assign in_ready_o = adv;

  // divider row, index 0 is the front end output
  tfcg_pkg::tag_t       tag_c [NUM_W+1];
  logic [FREQ_BITS-1:0] cur_c [NUM_W+1];
  logic [DEN_W-1:0]     rem_c [NUM_W+1];
  logic [NUM_W-1:0]     nq_c  [NUM_W+1];
  logic [DEN_W-1:0]     den_c [NUM_W+1];

  assign rem_c[0] = '0;

  tfcg_front #(
    .FREQ_BITS (FREQ_BITS),
    .TEMP_BITS (TEMP_BITS),
    .DIFF_W    (DIFF_W),
    .NUM_W     (NUM_W),
    .DEN_W     (DEN_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_valid_i (in_valid_i),
    .temp_i     (hottest_temp_mc_i),
    .cur_i      (current_cap_khz_i),
    .ps_i       (powersave_mode_i),
    .floor_i    (freq_floor_q),
    .ceil_i     (freq_ceiling_q),
    .normal_i   (temp_normal_q),
    .tol_i      (temp_tolerate_q),
    .crit_i     (temp_critical_q),
    .tag_o      (tag_c[0]),
    .cur_o      (cur_c[0]),
    .num_o      (nq_c[0]),
    .den_o      (den_c[0])
  );

  for (genvar g = 0; g < NUM_W; g++) begin : g_div
    tfcg_div_cell #(
      .FREQ_BITS (FREQ_BITS),
      .NUM_W     (NUM_W),
      .DEN_W     (DEN_W)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .tag_i  (tag_c[g]),
      .cur_i  (cur_c[g]),
      .rem_i  (rem_c[g]),
      .nq_i   (nq_c[g]),
      .den_i  (den_c[g]),
      .tag_o  (tag_c[g+1]),
      .cur_o  (cur_c[g+1]),
      .rem_o  (rem_c[g+1]),
      .nq_o   (nq_c[g+1]),
      .den_o  (den_c[g+1])
    );
  end

  tfcg_pkg::zone_e zone_out;

  tfcg_back #(
    .FREQ_BITS (FREQ_BITS),
    .NUM_W     (NUM_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .out_ready_i  (out_ready_i),
    .tag_i        (tag_c[NUM_W]),
    .cur_i        (cur_c[NUM_W]),
    .quo_i        (nq_c[NUM_W]),
    .floor_i      (freq_floor_q),
    .ceil_i       (freq_ceiling_q),
    .tail_valid_o (tail_valid),
    .out_valid_o  (out_valid_o),
    .cap_o        (new_cap_khz_o),
    .written_o    (cap_written_o),
    .zone_o       (zone_out)
  );

  assign zone_o = zone_out;

  `ASSERT_PROP(a_out_from_tail, clk_i, rst_ni, $rose(out_valid_o) |-> $past(tail_valid), "result appeared without an item at the pipe tail")
  `ASSERT_PROP(a_written_zone, clk_i, rst_ni, out_valid_o |-> (cap_written_o == (zone_o == tfcg_pkg::ZONE_HOT || zone_o == tfcg_pkg::ZONE_WARM || zone_o == tfcg_pkg::ZONE_COOL)), "written flag disagrees with zone")
  `ASSERT_PROP(a_cool_ceiling, clk_i, rst_ni, (out_valid_o && zone_o == tfcg_pkg::ZONE_COOL) |-> (new_cap_khz_o == freq_ceiling_q), "cool zone cap is not the ceiling")

endmodule

FILE: verif/tb_thermal_frequency_cap_governor_unit.sv
module tb_thermal_frequency_cap_governor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FREQ_BITS = 24;
  localparam int TEMP_BITS = 19;
  localparam logic [FREQ_BITS-1:0] FREQ_MAX = {FREQ_BITS{1'b1}};
  // watchdog limit, with a wide margin over the slowest run
  localparam int CYCLE_LIMIT = 200000;
  // pipe depth is 49 at the defaults
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 6;

  // one thermal tick as driven on the input channel
  typedef struct packed {
    logic signed [TEMP_BITS-1:0] temp;
    logic [FREQ_BITS-1:0]        cap;
    logic                        ps;
  } tick_t;

  // one cap decision as seen on the result channel
  typedef struct {
    logic [FREQ_BITS-1:0] cap;
    logic                 written;
    tfcg_pkg::zone_e      zone;
  } cap_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [tfcg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [tfcg_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic  in_valid = 1'b0;
  logic  in_ready;
  tick_t in_tick = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [FREQ_BITS-1:0] new_cap;
  logic                 cap_written;
  logic [2:0]           zone;

  // local copy of the register file, only changed while the pipe is empty
  logic [FREQ_BITS-1:0] floor_r = FREQ_BITS'(tfcg_pkg::FLOOR_RST);
  logic [FREQ_BITS-1:0] ceil_r = FREQ_BITS'(tfcg_pkg::CEILING_RST);
  tfcg_pkg::thr_t       normal_r = tfcg_pkg::NORMAL_RST;
  tfcg_pkg::thr_t       tolerate_r = tfcg_pkg::TOLERATE_RST;
  tfcg_pkg::thr_t       critical_r = tfcg_pkg::CRITICAL_RST;

  tick_t       ticks_pending[$];
  cap_result_t caps_expected[$];
  cap_result_t want_res;

  int   err_cnt = 0;
  int   cycle_cnt = 0;
  logic idle_on = 1'b1;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int   hold_left = 0;

  always #4 clk = ~clk;

  thermal_frequency_cap_governor_unit #(
    .FREQ_BITS(FREQ_BITS),
    .TEMP_BITS(TEMP_BITS)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .hottest_temp_mc_i(in_tick.temp),
    .current_cap_khz_i(in_tick.cap),
    .powersave_mode_i (in_tick.ps),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .new_cap_khz_o    (new_cap),
    .cap_written_o    (cap_written),
    .zone_o           (zone)
  );

  // step = span * (temp - from) / (10 * (to - from)), truncated toward zero;
  // an empty threshold span gives the whole frequency span
  function automatic longint cap_step(longint span, longint temp, longint from_thr,
                                      longint to_thr);
    longint den;
    den = 10 * (to_thr - from_thr);
    if (den == 0) return span;
    return (span * (temp - from_thr)) / den;
  endfunction

  // final cap is pinned to what the output field can carry
  function automatic logic [FREQ_BITS-1:0] sat_cap(longint v);
    if (v < 0) return '0;
    if (v > longint'(FREQ_MAX)) return FREQ_MAX;
    return v[FREQ_BITS-1:0];
  endfunction

  // what the governor should decide for one tick under the current registers
  function automatic cap_result_t govern_cap(tick_t t);
    cap_result_t r;
    longint tv, cur, lo, hi, span, v;
    tv   = longint'($signed(t.temp));
    cur  = longint'(t.cap);
    lo   = longint'(floor_r);
    hi   = longint'(ceil_r);
    span = hi - lo;
    r.cap     = t.cap;
    r.written = 1'b0;
    if (t.ps) begin
      // powersave wins over every temperature
      r.zone = tfcg_pkg::ZONE_PS;
    end else if (tv >= longint'(tolerate_r)) begin
      v = cur - cap_step(span, tv, longint'(tolerate_r), longint'(critical_r));
      if (v < lo) v = lo;
      r.cap     = sat_cap(v);
      r.written = 1'b1;
      r.zone    = tfcg_pkg::ZONE_HOT;
    end else if (tv >= longint'(normal_r)) begin
      v = cur + cap_step(span, tv, longint'(normal_r), longint'(tolerate_r));
      if (v > hi) v = hi;
      r.cap     = sat_cap(v);
      r.written = 1'b1;
      r.zone    = tfcg_pkg::ZONE_WARM;
    end else if (tv >= 0) begin
      r.cap     = ceil_r;
      r.written = 1'b1;
      r.zone    = tfcg_pkg::ZONE_COOL;
    end else begin
      // below zero the cap stays where it is
      r.zone = tfcg_pkg::ZONE_NEG;
    end
    return r;
  endfunction

  task automatic queue_tick(int temp, int cap, bit ps);
    tick_t t;
    t.temp = temp[TEMP_BITS-1:0];
    t.cap  = cap[FREQ_BITS-1:0];
    t.ps   = ps;
    ticks_pending.push_back(t);
  endtask

  // random ticks, biased toward the thresholds of the current setting
  task automatic queue_random_ticks(int n);
    int temp, base, cap;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: base = 0;
        1: base = int'(normal_r);
        2: base = int'(tolerate_r);
        default: base = int'(critical_r);
      endcase
      case ($urandom_range(9))
        0, 1, 2, 3: temp = base + int'($urandom_range(4000)) - 2000;
        4, 5: temp = int'($urandom_range(250000)) - 50000;
        6: temp = int'($urandom);
        7: temp = base;
        default: temp = int'($urandom_range(200000));
      endcase
      case ($urandom_range(7))
        0: cap = 0;
        1: cap = int'(FREQ_MAX);
        2: cap = int'(floor_r) + int'($urandom_range(100));
        3: cap = int'(ceil_r) - int'($urandom_range(100));
        default: cap = int'($urandom);
      endcase
      queue_tick(temp, cap, $urandom_range(9) == 0);
    end
  endtask

  // writes all five registers back to back, valid stays up between them
  task automatic write_regs(logic [31:0] f, logic [31:0] c, logic [31:0] n,
                            logic [31:0] t, logic [31:0] k);
    logic [tfcg_pkg::CFG_IDX_W-1:0] idx[5];
    logic [31:0] vals[5];
    idx  = '{tfcg_pkg::CFG_FLOOR, tfcg_pkg::CFG_CEILING, tfcg_pkg::CFG_NORMAL,
             tfcg_pkg::CFG_TOLERATE, tfcg_pkg::CFG_CRITICAL};
    vals = '{f, c, n, t, k};
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    // the register keeps only its own width
    floor_r    = f[FREQ_BITS-1:0];
    ceil_r     = c[FREQ_BITS-1:0];
    normal_r   = n[tfcg_pkg::THR_BITS-1:0];
    tolerate_r = t[tfcg_pkg::THR_BITS-1:0];
    critical_r = k[tfcg_pkg::THR_BITS-1:0];
  endtask

  // every tick yields a result, so an empty expectation list means an empty pipe
  task automatic drain_pipe();
    while (ticks_pending.size() != 0 || in_valid || caps_expected.size() != 0)
      @(posedge clk);
  endtask

  // input driver: predicts on each accepted transfer, then offers the next tick
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_tick  <= '0;
    end else begin
      if (in_valid && in_ready) caps_expected.push_back(govern_cap(in_tick));
      if (!in_valid || in_ready) begin
        if (ticks_pending.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
          in_tick  <= ticks_pending.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here so the monitor only reads it
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // result monitor: each transfer against the oldest expectation
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (caps_expected.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: cap %0d written %0b zone %0d",
                     new_cap, cap_written, zone);
        end else begin
          want_res = caps_expected.pop_front();
          if (new_cap !== want_res.cap || cap_written !== want_res.written ||
              zone !== want_res.zone) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display({"result mismatch: expected cap %0d written %0b zone %0d,",
                        " got cap %0d written %0b zone %0d"},
                       want_res.cap, want_res.written, want_res.zone,
                       new_cap, cap_written, zone);
          end
        end
      end
      out_ready <= (hold_left == 0) && !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_thermal_frequency_cap_governor_unit: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned n_thr, t_thr, k_thr;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: zone edges, field extremes, powersave over hot, cool and negative temperatures
    queue_tick(-262144, 1000000, 1'b0);
    queue_tick(-1, 1234567, 1'b0);
    queue_tick(-50000, 16777215, 1'b0);
    queue_tick(0, 0, 1'b0);
    queue_tick(49999, 16777215, 1'b0);
    queue_tick(50000, 800000, 1'b0);
    queue_tick(60000, 2990000, 1'b0);
    queue_tick(55555, 16777215, 1'b0);
    queue_tick(69999, 0, 1'b0);
    queue_tick(70000, 3000000, 1'b0);
    queue_tick(80000, 900000, 1'b0);
    queue_tick(89999, 16777215, 1'b0);
    queue_tick(90000, 3000000, 1'b0);
    queue_tick(100000, 0, 1'b0);
    queue_tick(200000, 16777215, 1'b0);
    queue_tick(262143, 5000000, 1'b0);
    queue_tick(75000, 1500000, 1'b1);
    queue_tick(-50000, 0, 1'b1);
    queue_tick(30000, 16777215, 1'b1);
    queue_random_ticks(180);
    // sink stalls while the source keeps pushing, pipe fills and backs up
    hold_req <= 1'b1;
    drain_pipe();

    // full frequency span, empty hot span; no idling on either side here
    idle_on <= 1'b0;
    write_regs(32'd0, 32'hFFFFFF, 32'd0, 32'd200000, 32'd200000);
    queue_random_ticks(110);
    drain_pipe();
    idle_on <= 1'b1;

    // floor above ceiling: steps flip sign and the cap saturates
    write_regs(32'hFFFFFF, 32'd0, 32'd10000, 32'd20000, 32'd30000);
    queue_random_ticks(110);
    drain_pipe();

    // thresholds out of order
    write_regs(32'd3000000, 32'd800000, 32'd60000, 32'd40000, 32'd100000);
    queue_random_ticks(110);
    drain_pipe();

    // zero range, widest thresholds, junk above the register widths
    write_regs(32'hFF0003E8, 32'h5A0003E8, 32'hFFFC0000, 32'h0007FFFF, 32'hFFFFFFFF);
    queue_random_ticks(110);
    drain_pipe();

    // random ordered settings
    for (int p = 0; p < 2; p++) begin
      n_thr = $urandom_range(60000);
      t_thr = n_thr + $urandom_range(70000);
      k_thr = t_thr + $urandom_range(70000);
      write_regs($urandom_range(4000000), $urandom_range(4000000), n_thr, t_thr, k_thr);
      queue_random_ticks(110);
      drain_pipe();
    end

    // fully random setting
    write_regs($urandom, $urandom, $urandom_range(200000), $urandom_range(200000),
               $urandom_range(200000));
    queue_random_ticks(110);
    drain_pipe();

    // let any stray result surface
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0 && caps_expected.size() == 0) begin
      $display("tb_thermal_frequency_cap_governor_unit: done, clean");
    end else begin
      $display("tb_thermal_frequency_cap_governor_unit: done, errors");
    end
    $finish;
  end

endmodule
